@@ hdl/servo_drive_enable_and_profile_defines.svh @@
// Assertion macros for the servo drive enable and profile block.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef SERVO_DRIVE_ENABLE_AND_PROFILE_DEFINES_SVH
`define SERVO_DRIVE_ENABLE_AND_PROFILE_DEFINES_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define SDEP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and quiet while reset is high.
`define SDEP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sdep_pkg.sv @@
// Shared types and constants for the servo drive enable and profile block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sdep_pkg;

   typedef logic [15:0]        status_word_type;
   typedef logic [15:0]        command_word_type;
   typedef logic signed [31:0] position_type;
   typedef logic signed [31:0] velocity_type;
   typedef logic [3:0]         mode_type;
   typedef logic [2:0]         drive_state_type;
   typedef logic [12:0]        phase_count_type;

   localparam int CNT_W = 13;

   // Decoded drive states
   localparam drive_state_type ST_NOT_READY      = 3'd0;
   localparam drive_state_type ST_DISABLED       = 3'd1;
   localparam drive_state_type ST_READY          = 3'd2;
   localparam drive_state_type ST_SWITCHED_ON    = 3'd3;
   localparam drive_state_type ST_OP_ENABLED     = 3'd4;
   localparam drive_state_type ST_QUICK_STOP     = 3'd5;
   localparam drive_state_type ST_FAULT_REACTION = 3'd6;
   localparam drive_state_type ST_FAULT          = 3'd7;

   // Status word masks and patterns
   localparam status_word_type SW_MASK_SHORT     = 16'h004F;
   localparam status_word_type SW_MASK_LONG      = 16'h006F;
   localparam status_word_type SW_DISABLED       = 16'h0040;
   localparam status_word_type SW_READY          = 16'h0021;
   localparam status_word_type SW_SWITCHED_ON    = 16'h0023;
   localparam status_word_type SW_OP_ENABLED     = 16'h0027;
   localparam status_word_type SW_QUICK_STOP     = 16'h0007;
   localparam status_word_type SW_FAULT_REACTION = 16'h000F;
   localparam status_word_type SW_FAULT          = 16'h0008;

   // Control words
   localparam command_word_type CMD_SHUTDOWN    = 16'h0006;
   localparam command_word_type CMD_SWITCH_ON   = 16'h0007;
   localparam command_word_type CMD_ENABLE      = 16'h000F;
   localparam command_word_type CMD_FAULT_RESET = 16'h0080;

   localparam mode_type MODE_CYCLIC_POSITION = 4'd8;

   // Configuration register map (word index, byte address = 4 * index)
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_VELOCITY_STEP  = 2'd0;
   localparam logic [1:0] CSR_PHASE_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_CRUISE_VEL_OUT = 2'd2;

   localparam logic [15:0] VELOCITY_STEP_RESET = 16'd10;
   localparam logic [9:0]  PHASE_LENGTH_RESET  = 10'd100;
   localparam velocity_type CRUISE_VEL_RESET   = 32'sd1310720;

endpackage

@@ hdl/sdep_req_if.sv @@
// Request channel: one control-cycle tick with the drive's status and position.
// Depends on sdep_pkg for the payload types.
`timescale 1ns / 1ps

interface sdep_req_if;
   logic                     valid;
   logic                     ready;
   sdep_pkg::status_word_type drive_status;
   sdep_pkg::position_type   actual_position;

   modport source (output valid, output drive_status, output actual_position, input ready);
   modport sink   (input valid, input drive_status, input actual_position, output ready);
endinterface

@@ hdl/sdep_rsp_if.sv @@
// Result channel: control word, targets and decoded state for one tick.
// Depends on sdep_pkg for the payload types.
`timescale 1ns / 1ps

interface sdep_rsp_if;
   logic                       valid;
   logic                       ready;
   sdep_pkg::command_word_type command_word;
   sdep_pkg::position_type     position_target;
   sdep_pkg::velocity_type     velocity_target;
   sdep_pkg::mode_type         operating_mode;
   logic                       drive_enabled;
   sdep_pkg::drive_state_type  drive_state;
   logic                       state_changed;

   modport source (output valid, output command_word, output position_target,
                   output velocity_target, output operating_mode, output drive_enabled,
                   output drive_state, output state_changed, input ready);
   modport sink   (input valid, input command_word, input position_target,
                   input velocity_target, input operating_mode, input drive_enabled,
                   input drive_state, input state_changed, output ready);
endinterface

@@ hdl/servo_drive_enable_and_profile.sv @@
// Servo drive enable sequencer with a six-phase velocity profile.
// Depends on sdep_pkg, sdep_req_if, sdep_rsp_if and the assertion macro header.
//
// Usage: each request on req_chan is one control-cycle tick carrying the drive's
// status word and actual position. The block decodes the drive state, chooses the
// control word that moves the drive towards operation enabled and, once enabled,
// advances a velocity profile (accelerate, cruise, decelerate twice, cruise,
// accelerate). One result per request leaves on rsp_chan.
// rsp_chan.valid rises once an accepted request has passed through the input
// register, then one pass of decode and 32-bit add logic into the result register.
// Throughput is one request per cycle while the receiver takes results and the
// remainder unit is idle; the profile state is updated as each request moves
// from the input register to the result register.
// When the receiver stalls, the result register holds and the input register
// fills; req_chan.ready falls once both are occupied.
// A write to phase_length starts a remainder of the phase counter by six times
// the new length, one quotient bit per cycle; no request is taken until it has
// finished.
// Synchronous reset empties both registers, restores the register defaults
// (step 10, phase length 100, cruise velocity 1310720) and clears all profile
// and held state. Configuration is written over the csr_ APB port while idle.
`timescale 1ns / 1ps
`include "servo_drive_enable_and_profile_defines.svh"

module servo_drive_enable_and_profile (
   input  logic                            clock,
   input  logic                            reset,
   sdep_req_if.sink                        req_chan,
   sdep_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sdep_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   // Configuration registers
   logic [15:0]            velocity_step_ff;
   logic [9:0]             phase_length_ff;
   sdep_pkg::velocity_type cruise_vel_ff;

   // Input register
   logic                      in_valid_ff;
   sdep_pkg::status_word_type in_status_ff;
   sdep_pkg::position_type    in_actual_ff;

   // Profile and held state
   sdep_pkg::phase_count_type  phase_counter_ff, phase_counter_in;
   logic [31:0]                profile_vel_ff, profile_vel_in;
   logic [31:0]                profile_pos_ff, profile_pos_in;
   sdep_pkg::drive_state_type  last_state_ff;
   sdep_pkg::command_word_type held_command_ff, held_command_in;
   sdep_pkg::mode_type         held_mode_ff, held_mode_in;
   sdep_pkg::velocity_type     held_vel_target_ff, held_vel_target_in;

   // Result register
   logic                       rsp_valid_ff;
   sdep_pkg::command_word_type rsp_command_ff;
   sdep_pkg::position_type     rsp_position_ff, rsp_position_in;
   sdep_pkg::velocity_type     rsp_velocity_ff;
   sdep_pkg::mode_type         rsp_mode_ff;
   logic                       rsp_enabled_ff;
   sdep_pkg::drive_state_type  rsp_state_ff;
   logic                       rsp_changed_ff;

   // Counter remainder unit
   logic                       rem_busy_ff;
   logic [3:0]                 rem_idx_ff;
   sdep_pkg::phase_count_type  rem_ff, rem_in;
   logic [sdep_pkg::CNT_W:0]   rem_trial, rem_diff;

   logic                       csr_write;
   logic                       len_write;
   logic                       advance;
   sdep_pkg::drive_state_type  st;
   logic                       enabled;
   sdep_pkg::phase_count_type  len1, len2, len4, len5, len6, cnt_inc;
   logic                       in_accel, in_decel, in_cycle;
   logic [31:0]                step_ext;

   function automatic sdep_pkg::drive_state_type decode_status(
      input sdep_pkg::status_word_type sw);
      sdep_pkg::status_word_type s_short;
      sdep_pkg::status_word_type s_long;
      s_short = sw & sdep_pkg::SW_MASK_SHORT;
      s_long  = sw & sdep_pkg::SW_MASK_LONG;
      if (s_short == sdep_pkg::SW_DISABLED)            return sdep_pkg::ST_DISABLED;
      else if (s_long == sdep_pkg::SW_READY)           return sdep_pkg::ST_READY;
      else if (s_long == sdep_pkg::SW_SWITCHED_ON)     return sdep_pkg::ST_SWITCHED_ON;
      else if (s_long == sdep_pkg::SW_OP_ENABLED)      return sdep_pkg::ST_OP_ENABLED;
      else if (s_long == sdep_pkg::SW_QUICK_STOP)      return sdep_pkg::ST_QUICK_STOP;
      else if (s_short == sdep_pkg::SW_FAULT_REACTION) return sdep_pkg::ST_FAULT_REACTION;
      else if (s_short == sdep_pkg::SW_FAULT)          return sdep_pkg::ST_FAULT;
      else                                             return sdep_pkg::ST_NOT_READY;
   endfunction

   // ---------------------------------------------------------------- APB port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign len_write  = csr_write && (csr_paddr[3:2] == sdep_pkg::CSR_PHASE_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_step_ff <= sdep_pkg::VELOCITY_STEP_RESET;
         phase_length_ff  <= sdep_pkg::PHASE_LENGTH_RESET;
         cruise_vel_ff    <= sdep_pkg::CRUISE_VEL_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            sdep_pkg::CSR_VELOCITY_STEP:  velocity_step_ff <= csr_pwdata[15:0];
            sdep_pkg::CSR_PHASE_LENGTH:   phase_length_ff  <= csr_pwdata[9:0];
            sdep_pkg::CSR_CRUISE_VEL_OUT: cruise_vel_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sdep_pkg::CSR_VELOCITY_STEP:  csr_prdata = {16'd0, velocity_step_ff};
         sdep_pkg::CSR_PHASE_LENGTH:   csr_prdata = {22'd0, phase_length_ff};
         sdep_pkg::CSR_CRUISE_VEL_OUT: csr_prdata = cruise_vel_ff;
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !rem_busy_ff && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_status_ff <= req_chan.drive_status;
         in_actual_ff <= req_chan.actual_position;
      end
   end

   // ---------------------------------------------------------------- phase bounds
   assign len1     = {3'd0, phase_length_ff};
   assign len2     = {2'd0, phase_length_ff, 1'b0};
   assign len4     = {1'b0, phase_length_ff, 2'b0};
   assign len5     = len4 + len1;
   assign len6     = len4 + len2;
   assign cnt_inc  = phase_counter_ff + 13'd1;
   assign step_ext = {16'd0, velocity_step_ff};

   assign in_cycle = phase_counter_ff < len6;
   assign in_accel = (phase_counter_ff < len1) ||
                     ((phase_counter_ff >= len5) && in_cycle);
   assign in_decel = (phase_counter_ff >= len2) && (phase_counter_ff < len4);

   // ---------------------------------------------------------------- remainder unit
   // Restoring remainder of the phase counter by the new cycle length, used when
   // the counter was left beyond the cycle by a shorter phase length.
   always_comb begin
      rem_trial = {rem_ff, phase_counter_ff[rem_idx_ff]};
      rem_diff  = rem_trial - {1'b0, len6};
      if (rem_trial >= {1'b0, len6}) begin
         rem_in = rem_diff[sdep_pkg::CNT_W-1:0];
      end else begin
         rem_in = rem_trial[sdep_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_busy_ff <= 1'b0;
         rem_idx_ff  <= 4'd0;
         rem_ff      <= '0;
      end else if (len_write) begin
         rem_busy_ff <= 1'b1;
         rem_idx_ff  <= 4'(sdep_pkg::CNT_W - 1);
         rem_ff      <= '0;
      end else if (rem_busy_ff) begin
         rem_ff <= rem_in;
         if (rem_idx_ff == 4'd0) begin
            rem_busy_ff <= 1'b0;
         end else begin
            rem_idx_ff <= rem_idx_ff - 4'd1;
         end
      end
   end

   // ---------------------------------------------------------------- tick logic
   assign st      = decode_status(in_status_ff);
   assign enabled = (st == sdep_pkg::ST_OP_ENABLED);

   always_comb begin
      held_command_in    = held_command_ff;
      held_mode_in       = held_mode_ff;
      held_vel_target_in = held_vel_target_ff;
      phase_counter_in   = phase_counter_ff;
      profile_vel_in     = profile_vel_ff;
      profile_pos_in     = profile_pos_ff;

      // Enabled, quick stop and fault reaction keep the last control word.
      case (st)
         sdep_pkg::ST_NOT_READY,
         sdep_pkg::ST_DISABLED:    held_command_in = sdep_pkg::CMD_SHUTDOWN;
         sdep_pkg::ST_READY:       held_command_in = sdep_pkg::CMD_SWITCH_ON;
         sdep_pkg::ST_SWITCHED_ON: begin
            held_command_in = sdep_pkg::CMD_ENABLE;
            held_mode_in    = sdep_pkg::MODE_CYCLIC_POSITION;
         end
         sdep_pkg::ST_FAULT:       held_command_in = sdep_pkg::CMD_FAULT_RESET;
         default: ;
      endcase

      if (enabled) begin
         held_vel_target_in = cruise_vel_ff;
         if (phase_length_ff == 10'd0) begin
            phase_counter_in = '0;
         end else if (in_cycle) begin
            if (in_accel) begin
               profile_vel_in = profile_vel_ff + step_ext;
            end else if (in_decel) begin
               profile_vel_in = profile_vel_ff - step_ext;
            end
            profile_pos_in   = profile_pos_ff + profile_vel_in;
            phase_counter_in = (cnt_inc == len6) ? '0 : cnt_inc;
         end else begin
            // Counter beyond the cycle: no phase this tick, only the reduction.
            phase_counter_in = rem_ff;
         end
         rsp_position_in = profile_pos_in;
      end else begin
         phase_counter_in = '0;
         profile_vel_in   = 32'd0;
         profile_pos_in   = in_actual_ff;
         rsp_position_in  = in_actual_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_counter_ff   <= '0;
         profile_vel_ff     <= 32'd0;
         profile_pos_ff     <= 32'd0;
         last_state_ff      <= sdep_pkg::ST_NOT_READY;
         held_command_ff    <= 16'd0;
         held_mode_ff       <= 4'd0;
         held_vel_target_ff <= 32'sd0;
      end else if (advance) begin
         phase_counter_ff   <= phase_counter_in;
         profile_vel_ff     <= profile_vel_in;
         profile_pos_ff     <= profile_pos_in;
         last_state_ff      <= st;
         held_command_ff    <= held_command_in;
         held_mode_ff       <= held_mode_in;
         held_vel_target_ff <= held_vel_target_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_command_ff  <= held_command_in;
         rsp_position_ff <= rsp_position_in;
         rsp_velocity_ff <= held_vel_target_in;
         rsp_mode_ff     <= held_mode_in;
         rsp_enabled_ff  <= enabled;
         rsp_state_ff    <= st;
         rsp_changed_ff  <= (st != last_state_ff);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.command_word    = rsp_command_ff;
   assign rsp_chan.position_target = rsp_position_ff;
   assign rsp_chan.velocity_target = rsp_velocity_ff;
   assign rsp_chan.operating_mode  = rsp_mode_ff;
   assign rsp_chan.drive_enabled   = rsp_enabled_ff;
   assign rsp_chan.drive_state     = rsp_state_ff;
   assign rsp_chan.state_changed   = rsp_changed_ff;

   // ---------------------------------------------------------------- assertions
   `SDEP_ASSERT_NEXT(a_len_write_starts_rem, len_write, rem_busy_ff, "remainder unit did not start")
   `SDEP_ASSERT_NOW(a_enabled_matches_state, rsp_valid_ff, rsp_enabled_ff == (rsp_state_ff == sdep_pkg::ST_OP_ENABLED), "enabled flag disagrees with state")
   `SDEP_ASSERT_NEXT(a_counter_within_cycle, advance && enabled && (phase_length_ff != 10'd0), phase_counter_ff < $past(len6), "phase counter left beyond cycle")
   `SDEP_ASSERT_NEXT(a_disabled_clears_velocity, advance && !enabled, profile_vel_ff == 32'd0, "profile velocity not cleared")
   `SDEP_ASSERT_NEXT(a_last_state_tracks, advance, last_state_ff == $past(st), "last state not recorded")

endmodule
